// ===== hw/rtl/tlfpq_pkg.sv =====
package tlfpq_pkg;

    // Default sizes handed to the top level parameters.
    localparam int FLOWS_DEFAULT       = 1024;
    localparam int QUEUE_DEPTH_DEFAULT = 256;
    localparam int HANDLE_BITS_DEFAULT = 32;

    // Fixed field widths.
    localparam int OPCODE_W    = 2;
    localparam int FLOW_ID_W   = 10;
    localparam int COUNT_W     = 32;
    localparam int THRESH_W    = 32;
    localparam int LIMIT_W     = 9;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT     = 1'd1;

    // Register reset values.
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 32'd150;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 9'd256;

    // Commands from the scheduler to one class FIFO.
    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
    } fifo_ctrl_t;

    // Status from one class FIFO back to the scheduler.
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

// ===== hw/rtl/tlfpq_class_fifo.sv =====
module tlfpq_class_fifo #(
    parameter int QUEUE_DEPTH = tlfpq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int HANDLE_BITS = tlfpq_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tlfpq_pkg::fifo_ctrl_t          ctrl,
    input  logic [HANDLE_BITS-1:0]         wr_data,
    input  logic [tlfpq_pkg::LIMIT_W-1:0]  limit,
    output logic [HANDLE_BITS-1:0]         rd_data,
    output tlfpq_pkg::fifo_status_t        status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (OCC_W > tlfpq_pkg::LIMIT_W) ? OCC_W : tlfpq_pkg::LIMIT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(QUEUE_DEPTH);

    logic [HANDLE_BITS-1:0] store_mem [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] rd_data_reg;

    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    // Descriptor store: one write port at the tail, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store_mem[wr_ptr_reg] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= store_mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

    // Full when the occupancy reaches the configured limit or the physical depth.
    assign status.empty = (occ_reg == '0);
    assign status.full  = (CMP_W'(occ_reg) >= CMP_W'(limit)) || (occ_reg == OCC_MAX);

    // Pointer and occupancy update; the pointers wrap at the depth.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        occ_next    = occ_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (ctrl.push && !ctrl.pop)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // The occupancy never exceeds the physical depth.
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= OCC_MAX)
        else $error("class FIFO occupancy above depth");

    // The scheduler never pushes into a full FIFO or pops an empty one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push |-> !status.full) and (ctrl.pop |-> !status.empty))
        else $error("class FIFO push when full or pop when empty");

    // At full occupancy the read and write pointers are equal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == OCC_MAX) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("class FIFO pointers disagree with full occupancy");

endmodule

// ===== hw/rtl/two_level_flow_priority_queue_unit.sv =====
// Two-class least-attained-service scheduler.
// Input channel (in_valid/in_stall) carries one operation: enqueue, dequeue
// or peek. Every operation yields exactly one result on the output channel
// (out_valid/out_stall). An enqueue looks up the packet count of its flow,
// picks the high class when the count is at or below the threshold and the
// low class otherwise, and bumps the saturating count. Dequeue and peek
// serve the high class first.
// Timing: an operation is taken and its counter and FIFO heads are read into
// registers; once the output register is free, the read-modify-write
// completes and the result is loaded into the output register. A new
// operation is accepted only after the held one completes, since the
// counter and descriptor memories have a registered read.
// Reset: the flow counter memory is swept to zero, one entry per cycle, over
// all FLOWS entries after reset; in_stall stays high during that sweep.
// Configuration writes (cfg_valid/cfg_ready) are always taken.
// A stalled result holds in the output register; the block still accepts one
// more operation and holds it until the output register frees.
module two_level_flow_priority_queue_unit #(
    parameter int FLOWS       = tlfpq_pkg::FLOWS_DEFAULT,
    parameter int QUEUE_DEPTH = tlfpq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int HANDLE_BITS = tlfpq_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Operation channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tlfpq_pkg::OPCODE_W-1:0]     opcode,
    input  logic [tlfpq_pkg::FLOW_ID_W-1:0]    flow_id,
    input  logic [HANDLE_BITS-1:0]             packet_handle,
    // Result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic                               chosen_class,
    output logic                               served_valid,
    output logic [HANDLE_BITS-1:0]             served_handle,
    output logic                               served_class,
    // Configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlfpq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlfpq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int FLOW_AW = $clog2(FLOWS);
    localparam int ID_W    = tlfpq_pkg::FLOW_ID_W;
    localparam int CNT_W   = tlfpq_pkg::COUNT_W;
    localparam logic [FLOW_AW-1:0] FLOW_LAST = FLOW_AW'(FLOWS - 1);

    // Wrap a flow number into the table by conditional subtraction of
    // shifted copies of the table size.
    function automatic logic [FLOW_AW-1:0] flow_wrap(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] v;
        v = id;
        for (int k = ID_W - 1; k >= 0; k--)
        begin
            if ((longint'(FLOWS) << k) < (longint'(1) << ID_W))
            begin
                if (v >= ID_W'(longint'(FLOWS) << k))
                begin
                    v = v - ID_W'(longint'(FLOWS) << k);
                end
            end
        end
        return FLOW_AW'(v);
    endfunction

    // Configuration registers
    logic [tlfpq_pkg::THRESH_W-1:0] threshold_reg;
    logic [tlfpq_pkg::LIMIT_W-1:0]  limit_reg;

    // Reset sweep of the counter memory
    logic               clear_active_reg;
    logic [FLOW_AW-1:0] clear_addr_reg;

    // Operation held between acceptance and completion
    logic                              exec_valid_reg;
    logic                              exec_valid_next;
    logic [tlfpq_pkg::OPCODE_W-1:0]    op_reg;
    logic [FLOW_AW-1:0]                flow_idx_reg;
    logic [HANDLE_BITS-1:0]            handle_reg;

    // Counter memory
    logic [CNT_W-1:0]   count_mem [FLOWS];
    logic [CNT_W-1:0]   cnt_rdata_reg;
    logic               cnt_we;
    logic [FLOW_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;

    // Class FIFOs
    tlfpq_pkg::fifo_ctrl_t   high_ctrl;
    tlfpq_pkg::fifo_ctrl_t   low_ctrl;
    tlfpq_pkg::fifo_status_t high_status;
    tlfpq_pkg::fifo_status_t low_status;
    logic [HANDLE_BITS-1:0]  high_rd_data;
    logic [HANDLE_BITS-1:0]  low_rd_data;

    // Output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   accepted_reg;
    logic                   accepted_next;
    logic                   chosen_class_reg;
    logic                   chosen_class_next;
    logic                   served_valid_reg;
    logic                   served_valid_next;
    logic [HANDLE_BITS-1:0] served_handle_reg;
    logic [HANDLE_BITS-1:0] served_handle_next;
    logic                   served_class_reg;
    logic                   served_class_next;

    logic in_accept;
    logic exec_fire;
    logic is_enqueue;
    logic is_dequeue;
    logic to_low;
    logic serve_high;
    logic serve_low;

    // Handshakes
    assign in_stall  = clear_active_reg || exec_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign exec_fire = exec_valid_reg && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tlfpq_pkg::THRESHOLD_RESET;
            limit_reg     <= tlfpq_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tlfpq_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                tlfpq_pkg::REG_LIMIT:     limit_reg     <= cfg_data[tlfpq_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Counter sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + FLOW_AW'(1);
            if (clear_addr_reg == FLOW_LAST)
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // Capture the operation while the memories are read.
    assign exec_valid_next = in_accept || (exec_valid_reg && !exec_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
        end
        else
        begin
            exec_valid_reg <= exec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg       <= opcode;
            flow_idx_reg <= flow_wrap(flow_id);
            handle_reg   <= packet_handle;
        end
    end

    // Class decision and service order.
    assign is_enqueue = (op_reg == tlfpq_pkg::OP_ENQUEUE);
    assign is_dequeue = (op_reg == tlfpq_pkg::OP_DEQUEUE);
    assign to_low     = (cnt_rdata_reg > threshold_reg);
    assign serve_high = !high_status.empty;
    assign serve_low  = high_status.empty && !low_status.empty;

    // Counter write back: the sweep during reset, then the saturating increment.
    assign cnt_we    = clear_active_reg || (exec_fire && is_enqueue && (cnt_rdata_reg != '1));
    assign cnt_waddr = clear_active_reg ? clear_addr_reg : flow_idx_reg;
    assign cnt_wdata = clear_active_reg ? '0 : cnt_rdata_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (in_accept)
        begin
            cnt_rdata_reg <= count_mem[flow_wrap(flow_id)];
        end
    end

    // FIFO commands: both heads are read on acceptance.
    always_comb
    begin
        high_ctrl.rd_en = in_accept;
        high_ctrl.push  = exec_fire && is_enqueue && !to_low && !high_status.full;
        high_ctrl.pop   = exec_fire && is_dequeue && serve_high;
        low_ctrl.rd_en  = in_accept;
        low_ctrl.push   = exec_fire && is_enqueue && to_low && !low_status.full;
        low_ctrl.pop    = exec_fire && is_dequeue && serve_low;
    end

    tlfpq_class_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_high_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (high_ctrl),
        .wr_data (handle_reg),
        .limit   (limit_reg),
        .rd_data (high_rd_data),
        .status  (high_status)
    );

    tlfpq_class_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_low_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (low_ctrl),
        .wr_data (handle_reg),
        .limit   (limit_reg),
        .rd_data (low_rd_data),
        .status  (low_status)
    );

    // Result fields; fields that do not apply to the operation stay zero.
    always_comb
    begin
        accepted_next      = 1'b0;
        chosen_class_next  = 1'b0;
        served_valid_next  = 1'b0;
        served_handle_next = '0;
        served_class_next  = 1'b0;
        unique case (op_reg)
            tlfpq_pkg::OP_ENQUEUE:
            begin
                accepted_next     = to_low ? !low_status.full : !high_status.full;
                chosen_class_next = to_low;
            end
            tlfpq_pkg::OP_DEQUEUE, tlfpq_pkg::OP_PEEK:
            begin
                if (serve_high)
                begin
                    served_valid_next  = 1'b1;
                    served_handle_next = high_rd_data;
                end
                else if (serve_low)
                begin
                    served_valid_next  = 1'b1;
                    served_handle_next = low_rd_data;
                    served_class_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register: loaded on completion, held while the receiver stalls.
    assign out_valid_next = exec_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            accepted_reg      <= accepted_next;
            chosen_class_reg  <= chosen_class_next;
            served_valid_reg  <= served_valid_next;
            served_handle_reg <= served_handle_next;
            served_class_reg  <= served_class_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign chosen_class  = chosen_class_reg;
    assign served_valid  = served_valid_reg;
    assign served_handle = served_handle_reg;
    assign served_class  = served_class_reg;

    // Operations never overlap: an acceptance is never followed by another
    // in the next cycle, since the counter read-modify-write is still open.
    assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> !in_accept)
        else $error("back-to-back acceptance during counter update");

    // The reset sweep ends only after it has written the last counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_active_reg) |-> ($past(clear_addr_reg) == FLOW_LAST))
        else $error("counter sweep ended early");

    // A pending operation waits while a stalled result occupies the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec_valid_reg && out_valid_reg && out_stall) |=> (exec_valid_reg && out_valid_reg))
        else $error("pending operation lost while output stalled");

    // A completed operation always shows a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) exec_fire |=> out_valid_reg)
        else $error("completed operation produced no result");

endmodule
